### design/m2h_pkg.sv
// m2h_pkg: shared types and constants for the murmur2_hash32 block.
// Holds the mix multiplier, shift amounts, sequencer states and the tail mask.
// No dependencies.
package m2h_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    localparam logic [2:0]  CNT_NONE    = 3'd0;
    localparam logic [2:0]  CNT_ONE     = 3'd1;
    localparam logic [2:0]  CNT_TWO     = 3'd2;
    localparam logic [2:0]  CNT_THREE   = 3'd3;
    localparam logic [2:0]  CNT_FULL    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A,
        S_B,
        S_T,
        S_F1,
        S_F2
    } t_state;

    function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
        logic [31:0] m;
        case (cnt)
            CNT_ONE:   m = 32'h0000_00ff;
            CNT_TWO:   m = 32'h0000_ffff;
            CNT_THREE: m = 32'h00ff_ffff;
            default:   m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

### design/m2h_mul.sv
// m2h_mul: shared multiply-by-M unit with a registered product.
// The product holds while the enable is low.
// Depends on m2h_pkg.
module m2h_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_operand,
    output logic [31:0] o_product
);

    logic [31:0] r_prod;
    logic [31:0] n_prod;

    assign n_prod = i_operand * m2h_pkg::MIX_MUL;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_product = r_prod;

endmodule

### design/murmur2_hash32.sv
// murmur2_hash32: 32-bit MurmurHash2 over a key streamed as little-endian words.
// Top level: sequencer, running hash and output register around m2h_mul.
// Depends on m2h_pkg and m2h_mul.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one key word per transfer, with
//   byte count, first and last flags and, on the first word, the key length.
//   Output channel (o_out_valid / i_out_stall): one hash per key, sent after
//   the transfer that carries the last flag.
//   Config channel (i_cfg_valid / o_cfg_ready): writes the seed; always ready.
// Per full word the sequencer steps idle, S_A, S_B (word multiply, hash
//   multiply, second word multiply on the one shared multiplier) and stalls
//   input outside idle; the mixed word is folded into the hash in the first
//   idle cycle after S_B, which can also take the next word. After the last
//   word: no bytes, S_F2; 1 to 3 tail bytes, S_T, S_F1, S_F2; a full word,
//   S_A, S_B, S_F1, S_F2 (avalanche adds a multiply pass); then o_out_valid.
// Reset clears the seed, the running hash and the output valid.
// While the receiver stalls, the hash waits in the final state and the
//   output register holds; no new word is taken until it is written.
module murmur2_hash32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_word_data,
    input  logic [2:0]  i_byte_count,
    input  logic        i_first_item,
    input  logic        i_last_item,
    input  logic [30:0] i_total_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    m2h_pkg::t_state r_state, n_state;

    logic [31:0] r_seed;
    logic [31:0] r_hash, n_hash;
    logic [31:0] r_k, n_k;
    logic        r_pend, n_pend;
    logic        r_last, n_last;
    logic [31:0] r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic        mul_en;
    logic [31:0] mul_op;
    logic [31:0] prod;

    logic        accept;
    logic [2:0]  cnt_sat;
    logic        is_full, is_zero;
    logic [31:0] h_cur, h_init, h_fold, h_fin;

    m2h_mul u_mul (
        .i_clk     (i_clk),
        .i_en      (mul_en),
        .i_operand (mul_op),
        .o_product (prod)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_state != m2h_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out;
    assign accept       = i_in_valid && !o_in_stall;

    assign cnt_sat = (i_byte_count > m2h_pkg::CNT_FULL) ? m2h_pkg::CNT_FULL : i_byte_count;
    assign is_full = !i_last_item || (cnt_sat == m2h_pkg::CNT_FULL);
    assign is_zero = i_last_item && (cnt_sat == m2h_pkg::CNT_NONE);

    assign h_cur  = r_pend ? (r_hash ^ prod) : r_hash;
    assign h_init = i_first_item ? (r_seed ^ {1'b0, i_total_length}) : h_cur;
    assign h_fold = r_hash ^ prod;
    assign h_fin  = prod ^ (prod >> m2h_pkg::FIN_SHIFT_B);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'h0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= m2h_pkg::S_IDLE;
            r_hash      <= 32'h0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_last <= n_last;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_pend      = r_pend;
        n_k         = r_k;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mul_en      = 1'b0;
        mul_op      = r_hash;
        case (r_state)
            m2h_pkg::S_IDLE: begin
                n_hash = h_cur;
                n_pend = 1'b0;
                if (accept) begin
                    n_last = i_last_item;
                    if (is_full) begin
                        n_hash  = h_init;
                        mul_en  = 1'b1;
                        mul_op  = i_word_data;
                        n_state = m2h_pkg::S_A;
                    end else if (is_zero) begin
                        n_hash  = h_init;
                        mul_en  = 1'b1;
                        mul_op  = h_init ^ (h_init >> m2h_pkg::FIN_SHIFT_A);
                        n_state = m2h_pkg::S_F2;
                    end else begin
                        n_hash  = h_init ^ (i_word_data & m2h_pkg::tail_mask(cnt_sat));
                        n_state = m2h_pkg::S_T;
                    end
                end
            end
            m2h_pkg::S_A: begin
                n_k     = prod ^ (prod >> m2h_pkg::MIX_SHIFT);
                mul_en  = 1'b1;
                mul_op  = r_hash;
                n_state = m2h_pkg::S_B;
            end
            m2h_pkg::S_B: begin
                n_hash = prod;
                mul_en = 1'b1;
                mul_op = r_k;
                if (r_last) begin
                    n_state = m2h_pkg::S_F1;
                end else begin
                    n_pend  = 1'b1;
                    n_state = m2h_pkg::S_IDLE;
                end
            end
            m2h_pkg::S_T: begin
                mul_en  = 1'b1;
                mul_op  = r_hash;
                n_hash  = 32'h0;
                n_state = m2h_pkg::S_F1;
            end
            m2h_pkg::S_F1: begin
                n_hash  = h_fold;
                mul_en  = 1'b1;
                mul_op  = h_fold ^ (h_fold >> m2h_pkg::FIN_SHIFT_A);
                n_state = m2h_pkg::S_F2;
            end
            m2h_pkg::S_F2: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = h_fin;
                    n_out_valid = 1'b1;
                    n_state     = m2h_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = m2h_pkg::S_IDLE;
            end
        endcase
    end

    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_item && (i_byte_count == m2h_pkg::CNT_NONE))
        |=> (r_state == m2h_pkg::S_F2))
        else $error("empty last word did not go straight to avalanche");

    a_mid_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == m2h_pkg::S_B && !r_last)
        |=> (r_state == m2h_pkg::S_IDLE && r_pend))
        else $error("mid-key word did not leave a pending fold");

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == m2h_pkg::S_IDLE))
        else $error("pending fold outside idle");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == m2h_pkg::S_F2))
        else $error("output written outside final state");

endmodule
